// ===== sv/suffix_automaton_builder_top_assert.svh =====
// Assertion macros used by the checker file sab_checker.
`ifndef SUFFIX_AUTOMATON_BUILDER_TOP_ASSERT_SVH
`define SUFFIX_AUTOMATON_BUILDER_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SAB_ASSERT_IMP(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define SAB_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`endif

// ===== sv/sab_pkg.sv =====
// ----------------------------------------------------------------------------
// sab_pkg
// Shared types and constants of the suffix automaton builder.
// ----------------------------------------------------------------------------
`default_nettype none
package sab_pkg;
   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   typedef struct packed {
      logic       command;
      logic [7:0] symbol;
      logic [8:0] query_state;
   } req_type;

   typedef struct packed {
      logic       full_flag;
      logic [9:0] state_count;
      logic       target_is_clone;
      logic [8:0] target_length;
      logic       target_valid;
      logic [8:0] target_state;
   } rsp_type;
endpackage
`default_nettype wire

// ===== sv/sab_ram.sv =====
// ----------------------------------------------------------------------------
// sab_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module sab_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output      logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

// ===== sv/sab_core.sv =====
// ----------------------------------------------------------------------------
// sab_core
// Sequencer that builds the automaton in the transition and state memories.
// ----------------------------------------------------------------------------
`default_nettype none
module sab_core import sab_pkg::*; #(
   parameter int MAX_LEN  = 256,
   parameter int ALPHABET = 256
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output      logic    in_ready,
   input  wire req_type in_word,
   output      logic    out_valid,
   input  wire logic    out_ready,
   output      rsp_type out_word
);
   localparam int STATES = 2 * MAX_LEN;
   localparam int SW = $clog2(STATES);
   localparam int AW = $clog2(ALPHABET) > 0 ? $clog2(ALPHABET) : 1;
   localparam int TW = SW + AW;
   localparam int LW = $clog2(MAX_LEN + 1);
   localparam int CW = SW + 1;
   localparam int IW = 1 + SW + LW;  // clone, link, length

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_QRD, S_QRD2, S_QRESP, S_WALK, S_WALKW, S_QCHK,
      S_CPRD, S_CPWR, S_REDIR, S_REDIRW, S_FIN, S_OUT
   } st_type;

   st_type          st_ff, st_in;
   logic [TW:0]     clr_ff, clr_in;
   logic [AW-1:0]   sym_ff, sym_in;
   logic [SW-1:0]   p_ff, p_in, q_ff, q_in, cur_ff, cur_in, last_ff, last_in;
   logic [SW-1:0]   cl_ff, cl_in;
   logic [CW-1:0]   used_ff, used_in;
   logic [LW-1:0]   plen_ff, plen_in, lastlen_ff, lastlen_in;
   logic [AW:0]     cp_ff, cp_in;
   logic            out_valid_ff, out_valid_in;
   rsp_type         out_ff, out_in;

   // transition memory: {valid, target}
   logic            t_we;
   logic [TW-1:0]   t_addr;
   logic [SW:0]     t_wd, t_rd;
   // state memory: {clone, link, length}
   logic            i_we;
   logic [SW-1:0]   i_addr;
   logic [IW-1:0]   i_wd, i_rd;

   sab_ram #(.WIDTH(SW + 1), .DEPTH(1 << TW)) u_trans (
      .clock(clock), .we(t_we), .addr(t_addr), .wdata(t_wd), .rdata(t_rd));
   sab_ram #(.WIDTH(IW), .DEPTH(STATES)) u_info (
      .clock(clock), .we(i_we), .addr(i_addr), .wdata(i_wd), .rdata(i_rd));

   wire            t_ok  = t_rd[SW];
   wire [SW-1:0]   t_tgt = t_rd[SW-1:0];
   wire            i_cl  = i_rd[IW-1];
   wire [SW-1:0]   i_lnk = i_rd[LW+SW-1:LW];
   wire [LW-1:0]   i_len = i_rd[LW-1:0];

   assign in_ready  = (st_ff == S_IDLE) && !out_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_word  = out_ff;

   always_comb begin
      st_in = st_ff; clr_in = clr_ff; sym_in = sym_ff; p_in = p_ff; q_in = q_ff;
      cur_in = cur_ff; last_in = last_ff; cl_in = cl_ff; used_in = used_ff;
      plen_in = plen_ff; lastlen_in = lastlen_ff; cp_in = cp_ff;
      out_valid_in = out_valid_ff && !out_ready; out_in = out_ff;
      t_we = 1'b0; t_addr = {p_ff, sym_ff}; t_wd = '0;
      i_we = 1'b0; i_addr = p_ff; i_wd = '0;
      unique case (st_ff)
         S_CLEAR: begin
            t_we = 1'b1; t_addr = clr_ff[TW-1:0];
            i_we = 1'b1; i_addr = clr_ff[SW-1:0];
            clr_in = clr_ff + 1'b1;
            if (clr_ff[TW]) st_in = S_IDLE;
         end
         S_IDLE: begin
            if (in_valid && in_ready) begin
               sym_in = in_word.symbol[AW-1:0];
               out_in = '0;
               out_in.state_count = used_ff;
               if (in_word.command == CMD_QUERY) begin
                  p_in = in_word.query_state[SW-1:0];
                  if ({1'b0, in_word.symbol} >= 9'(ALPHABET) ||
                      {1'b0, in_word.query_state} >= used_ff) begin
                     out_valid_in = 1'b1;
                  end else st_in = S_QRD;
               end else if (32'(lastlen_ff) >= MAX_LEN || 32'(used_ff) + 2 > STATES) begin
                  out_in.full_flag = 1'b1; out_valid_in = 1'b1;
               end else if ({1'b0, in_word.symbol} >= 9'(ALPHABET)) begin
                  out_valid_in = 1'b1;
               end else begin
                  cur_in = used_ff[SW-1:0];
                  used_in = used_ff + 1'b1;
                  p_in = last_ff;
                  // new state: length last+1, link root
                  i_we = 1'b1; i_addr = used_ff[SW-1:0];
                  i_wd = {1'b0, {SW{1'b0}}, LW'(lastlen_ff + 1'b1)};
                  st_in = S_WALK;
               end
            end
         end
         S_QRD: begin
            t_addr = {p_ff, sym_ff}; st_in = S_QRD2;
         end
         S_QRD2: begin
            if (t_ok) begin
               q_in = t_tgt; i_addr = t_tgt; st_in = S_QRESP;
            end else begin
               out_valid_in = 1'b1; st_in = S_IDLE;
            end
         end
         S_QRESP: begin
            out_in.target_state = 9'(q_ff); out_in.target_valid = 1'b1;
            out_in.target_length = 9'(i_len); out_in.target_is_clone = i_cl;
            out_valid_in = 1'b1; st_in = S_IDLE;
         end
         S_WALK: begin
            // read transition and info of p
            t_addr = {p_ff, sym_ff}; i_addr = p_ff; st_in = S_WALKW;
         end
         S_WALKW: begin
            if (t_ok) begin
               q_in = t_tgt; plen_in = i_len; i_addr = t_tgt; st_in = S_QCHK;
            end else begin
               t_we = 1'b1; t_addr = {p_ff, sym_ff}; t_wd = {1'b1, cur_ff};
               if (p_ff == '0) st_in = S_FIN;
               else begin p_in = i_lnk; st_in = S_WALK; end
            end
         end
         S_QCHK: begin
            if (LW'(plen_ff + 1'b1) == i_len) begin
               i_we = 1'b1; i_addr = cur_ff;
               i_wd = {1'b0, q_ff, LW'(lastlen_ff + 1'b1)};
               st_in = S_FIN;
            end else begin
               cl_in = used_ff[SW-1:0]; used_in = used_ff + 1'b1;
               // clone info: link of q, length p+1, marked
               i_we = 1'b1; i_addr = used_ff[SW-1:0];
               i_wd = {1'b1, i_lnk, LW'(plen_ff + 1'b1)};
               cp_in = '0; st_in = S_CPRD;
            end
         end
         S_CPRD: begin
            t_addr = {q_ff, cp_ff[AW-1:0]}; st_in = S_CPWR;
         end
         S_CPWR: begin
            t_we = 1'b1; t_addr = {cl_ff, cp_ff[AW-1:0]}; t_wd = t_rd;
            cp_in = cp_ff + 1'b1;
            if (32'(cp_ff) == ALPHABET - 1) begin
               // point the suffix link of cur at the clone
               i_addr = cur_ff; i_we = 1'b1;
               i_wd = {1'b0, cl_ff, LW'(lastlen_ff + 1'b1)};
               st_in = S_REDIR;
            end else st_in = S_CPRD;
         end
         S_REDIR: begin
            t_addr = {p_ff, sym_ff}; i_addr = p_ff; st_in = S_REDIRW;
         end
         S_REDIRW: begin
            if (!t_ok || t_tgt != q_ff) st_in = S_FIN;
            else begin
               t_we = 1'b1; t_addr = {p_ff, sym_ff}; t_wd = {1'b1, cl_ff};
               if (p_ff == '0) st_in = S_FIN;
               else begin p_in = i_lnk; st_in = S_REDIR; end
            end
            // q link := clone; q length/clone unchanged, read back below
            if (st_in == S_FIN) begin i_addr = q_ff; end
            cur_in = cur_ff;
         end
         S_FIN: begin
            // when cloned, rewrite q info with link to clone
            if (cl_ff != '0 && q_ff != '0 && used_ff[SW-1:0] == SW'(cl_ff + 1'b1)) begin
               i_we = 1'b1; i_addr = q_ff; i_wd = {i_cl, cl_ff, i_len};
            end
            st_in = S_OUT;
         end
         S_OUT: begin
            last_in = cur_ff; lastlen_in = LW'(lastlen_ff + 1'b1); cl_in = '0;
            out_in.target_state = 9'(cur_ff); out_in.target_valid = 1'b1;
            out_in.target_length = 9'(lastlen_ff + 1'b1);
            out_in.state_count = used_ff;
            out_valid_in = 1'b1; st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_CLEAR; clr_ff <= '0; used_ff <= CW'(1); last_ff <= '0;
         lastlen_ff <= '0; out_valid_ff <= 1'b0; cl_ff <= '0;
      end else begin
         st_ff <= st_in; clr_ff <= clr_in; used_ff <= used_in; last_ff <= last_in;
         lastlen_ff <= lastlen_in; out_valid_ff <= out_valid_in; cl_ff <= cl_in;
      end
      sym_ff <= sym_in; p_ff <= p_in; q_ff <= q_in; cur_ff <= cur_in;
      plen_ff <= plen_in; cp_ff <= cp_in; out_ff <= out_in;
   end
endmodule
`default_nettype wire

// ===== sv/suffix_automaton_builder_top.sv =====
// ----------------------------------------------------------------------------
// suffix_automaton_builder_top
// Online suffix automaton builder with transition queries.
// ----------------------------------------------------------------------------
// The request channel takes one word per item: an append of a symbol or a
// query of one transition. Every word returns exactly one response word.
// A query reads the transition and, when it exists, the target's state
// entry before it answers; rejected items answer in the next cycle.
// An append reads each state on the suffix-link walk and writes its missing
// transition; a walk that stops on an existing transition checks its target,
// and a clone copies the row through the single transition memory port and
// redirects the transitions that pointed at q on a second walk.
// After reset a clearing pass writes every transition entry, one per cycle,
// before the first request word is taken. A stalled response holds and no
// new request word is taken until it leaves.
// ----------------------------------------------------------------------------
`default_nettype none
module suffix_automaton_builder_top import sab_pkg::*; #(
   parameter int MAX_LEN  = 256,
   parameter int ALPHABET = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // command, symbol[8], query_state[9], zero pad
   input  wire logic [23:0] req_tdata,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // target_state[9], target_valid, target_length[9], target_is_clone,
   // state_count[10], full_flag, zero pad
   output      logic [31:0] rsp_tdata
);
   req_type req_word;
   rsp_type rsp_word;

   assign req_word.command     = req_tdata[0];
   assign req_word.symbol      = req_tdata[8:1];
   assign req_word.query_state = req_tdata[17:9];
   assign rsp_tdata = {1'b0, rsp_word};

   sab_core #(.MAX_LEN(MAX_LEN), .ALPHABET(ALPHABET)) u_core (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_word(req_word),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_word(rsp_word));
endmodule
`default_nettype wire

// ===== sv/sab_checker.sv =====
// ----------------------------------------------------------------------------
// sab_checker
// Port-level checks of the builder's handshakes and response fields.
// ----------------------------------------------------------------------------
`default_nettype none
`include "suffix_automaton_builder_top_assert.svh"
module sab_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);
   `SAB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled response changed")
   `SAB_ASSERT_IMP(a_no_take_busy, clock, reset, rsp_tvalid, !req_tready, "request taken while response pending")
   `SAB_ASSERT_IMP(a_full_invalid, clock, reset, rsp_tvalid && rsp_tdata[30], !rsp_tdata[9], "full response marked valid")
   `SAB_ASSERT_IMP(a_count_nonzero, clock, reset, rsp_tvalid, rsp_tdata[29:20] != 10'd0, "zero state count")
endmodule

bind suffix_automaton_builder_top sab_checker u_sab_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));
`default_nettype wire
